[src/bmg_pkg.sv]
package bmg_pkg;

    localparam int LOG_FRAC    = 28;
    localparam int ANGLE_STEPS = 30;
    localparam int SQRT_STEPS  = 27;
    localparam int RAD_LAT     = 2 + LOG_FRAC + 2 + SQRT_STEPS;
    localparam int ANG_LAT     = 2 * ANGLE_STEPS + 1;
    localparam int FIN_STAGES  = 4;

    localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;
    localparam logic [31:0] ONE_Q30     = 32'h4000_0000;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    localparam logic [23:0] MEAN_RESET   = 24'd0;
    localparam logic [15:0] SPREAD_RESET = 16'd256;

    localparam logic signed [63:0] SAMPLE_MAX = 64'sd8388607;
    localparam logic signed [63:0] SAMPLE_MIN = -64'sd8388608;

    typedef struct packed {
        logic [31:0] c;
        logic [31:0] s;
    } rot_pair_t;

    // Rounding right shift, half away from zero.
    function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                       input int n);
        logic signed [63:0] half;
        logic signed [63:0] mag;
        half = 64'sd1 <<< (n - 1);
        if (!v[63]) begin
            round_shift = (v + half) >>> n;
        end else begin
            mag = (-v + half) >>> n;
            round_shift = -mag;
        end
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] value);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bitv;
        v    = value;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (bitv > v) begin
                bitv = bitv >> 2;
            end
        end
        for (int i = 0; i < 32; i++) begin
            if (bitv != 64'd0) begin
                if (v >= res + bitv) begin
                    v   = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        isqrt64 = res;
    endfunction

    // Restoring long division, elaboration only.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = 65'd0;
        quo = 64'd0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        udiv64 = quo;
    endfunction

    // Cosine and sine of (pi/2)/2^k in Q.30, built by half-angle steps.
    function automatic rot_pair_t rot_entry(input int k);
        logic [63:0] c;
        logic [63:0] s;
        logic [63:0] v;
        logic [63:0] ck;
        logic [63:0] sk;
        logic [63:0] den;
        c = 64'd0;
        s = 64'd1 << 30;
        for (int j = 1; j <= ANGLE_STEPS; j++) begin
            if (j <= k) begin
                v   = ((64'd1 << 30) + c) >> 1;
                ck  = isqrt64(v << 30);
                den = ck << 1;
                sk  = udiv64((s << 30) + (den >> 1), den);
                c   = ck;
                s   = sk;
            end
        end
        rot_entry.c = c[31:0];
        rot_entry.s = s[31:0];
    endfunction

endpackage

[src/bmg_radius.sv]
module bmg_radius #(
    parameter int EFF_BITS = 32
) (
    input  logic        aclk,
    input  logic        adv,
    input  logic [31:0] m_in,
    output logic [26:0] r_out
);
    import bmg_pkg::*;

    logic [31:0] n1_x_reg;
    logic [4:0]  n1_lz_reg;
    logic [31:0] n2_x_reg;
    logic [5:0]  n2_epi_reg;

    logic [31:0] lg_x_reg   [1:LOG_FRAC];
    logic [27:0] lg_f_reg   [1:LOG_FRAC];
    logic [5:0]  lg_epi_reg [1:LOG_FRAC];

    logic [47:0] p1_lo_reg;
    logic [47:0] p1_hi_reg;
    logic [35:0] p2_r2_reg;

    logic [53:0] sq_v_reg   [1:SQRT_STEPS];
    logic [53:0] sq_res_reg [1:SQRT_STEPS];

    logic [31:0] n1_x_next;
    logic [4:0]  n1_lz_next;
    logic [31:0] n2_x_next;
    logic [4:0]  n2_lz_next;
    logic [33:0] t_val;
    logic [63:0] r2_sum;

    // Normalize in two halves: 16 and 8, then 4, 2 and 1.
    always_comb begin
        n1_x_next  = m_in;
        n1_lz_next = 5'd0;
        if (n1_x_next[31:16] == 16'd0) begin
            n1_x_next  = n1_x_next << 16;
            n1_lz_next = n1_lz_next + 5'd16;
        end
        if (n1_x_next[31:24] == 8'd0) begin
            n1_x_next  = n1_x_next << 8;
            n1_lz_next = n1_lz_next + 5'd8;
        end
        n2_x_next  = n1_x_reg;
        n2_lz_next = n1_lz_reg;
        if (n2_x_next[31:28] == 4'd0) begin
            n2_x_next  = n2_x_next << 4;
            n2_lz_next = n2_lz_next + 5'd4;
        end
        if (n2_x_next[31:30] == 2'd0) begin
            n2_x_next  = n2_x_next << 2;
            n2_lz_next = n2_lz_next + 5'd2;
        end
        if (!n2_x_next[31]) begin
            n2_x_next  = n2_x_next << 1;
            n2_lz_next = n2_lz_next + 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            n1_x_reg   <= n1_x_next;
            n1_lz_reg  <= n1_lz_next;
            n2_x_reg   <= n2_x_next;
            n2_epi_reg <= 6'(EFF_BITS + int'(n2_lz_next) - 31);
        end
    end

    // One squaring per stage yields one fraction bit of log2.
    for (genvar j = 1; j <= LOG_FRAC; j++) begin : g_log
        localparam logic [27:0] FBIT = 28'd1 << (LOG_FRAC - j);
        logic [31:0] src_x;
        logic [27:0] src_f;
        logic [5:0]  src_epi;
        logic [63:0] sq;
        if (j == 1) begin : g_first
            assign src_x   = n2_x_reg;
            assign src_f   = 28'd0;
            assign src_epi = n2_epi_reg;
        end else begin : g_rest
            assign src_x   = lg_x_reg[j-1];
            assign src_f   = lg_f_reg[j-1];
            assign src_epi = lg_epi_reg[j-1];
        end
        assign sq = src_x * src_x;
        always_ff @(posedge aclk) begin
            if (adv) begin
                lg_epi_reg[j] <= src_epi;
                if (sq[63]) begin
                    lg_x_reg[j] <= sq[63:32];
                    lg_f_reg[j] <= src_f | FBIT;
                end else begin
                    lg_x_reg[j] <= sq[62:31];
                    lg_f_reg[j] <= src_f;
                end
            end
        end
    end

    assign t_val  = {lg_epi_reg[LOG_FRAC], 28'd0} - {6'd0, lg_f_reg[LOG_FRAC]};
    assign r2_sum = ({16'd0, p1_hi_reg} << 17) + {16'd0, p1_lo_reg} + (64'd1 << 27);

    // Split the 34 by 31 product over two stages.
    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_lo_reg <= t_val[16:0] * TWO_LN2_Q30;
            p1_hi_reg <= t_val[33:17] * TWO_LN2_Q30;
            p2_r2_reg <= r2_sum[63:28];
        end
    end

    // One root bit per stage.
    for (genvar j = 1; j <= SQRT_STEPS; j++) begin : g_sqrt
        localparam logic [53:0] BITV = 54'd1 << (2 * (SQRT_STEPS - j));
        logic [53:0] src_v;
        logic [53:0] src_res;
        logic [53:0] trial;
        if (j == 1) begin : g_first
            assign src_v   = {p2_r2_reg, 18'd0};
            assign src_res = 54'd0;
        end else begin : g_rest
            assign src_v   = sq_v_reg[j-1];
            assign src_res = sq_res_reg[j-1];
        end
        assign trial = src_res + BITV;
        always_ff @(posedge aclk) begin
            if (adv) begin
                if (src_v >= trial) begin
                    sq_v_reg[j]   <= src_v - trial;
                    sq_res_reg[j] <= (src_res >> 1) + BITV;
                end else begin
                    sq_v_reg[j]   <= src_v;
                    sq_res_reg[j] <= src_res >> 1;
                end
            end
        end
    end

    assign r_out = sq_res_reg[SQRT_STEPS][26:0];

endmodule

[src/bmg_rotator.sv]
module bmg_rotator (
    input  logic               aclk,
    input  logic               adv,
    input  logic [1:0]         quad_in,
    input  logic [29:0]        frac_in,
    output logic signed [32:0] cos_out,
    output logic signed [32:0] sin_out
);
    import bmg_pkg::*;

    logic signed [63:0] a_pcc_reg [1:ANGLE_STEPS];
    logic signed [63:0] a_pss_reg [1:ANGLE_STEPS];
    logic signed [63:0] a_pcs_reg [1:ANGLE_STEPS];
    logic signed [63:0] a_psc_reg [1:ANGLE_STEPS];
    logic signed [32:0] a_cx_reg  [1:ANGLE_STEPS];
    logic signed [32:0] a_sy_reg  [1:ANGLE_STEPS];
    logic [29:0]        a_frac_reg[1:ANGLE_STEPS];
    logic [1:0]         a_quad_reg[1:ANGLE_STEPS];
    logic signed [32:0] b_cx_reg  [1:ANGLE_STEPS];
    logic signed [32:0] b_sy_reg  [1:ANGLE_STEPS];
    logic [29:0]        b_frac_reg[1:ANGLE_STEPS];
    logic [1:0]         b_quad_reg[1:ANGLE_STEPS];
    logic signed [32:0] cos_reg;
    logic signed [32:0] sin_reg;

    // Each rotation: products in one stage, sum and round in the next.
    for (genvar k = 1; k <= ANGLE_STEPS; k++) begin : g_rot
        localparam rot_pair_t ROT = rot_entry(k);
        logic signed [32:0] src_cx;
        logic signed [32:0] src_sy;
        logic [29:0]        src_frac;
        logic [1:0]         src_quad;
        logic signed [63:0] nx;
        logic signed [63:0] ny;
        if (k == 1) begin : g_first
            assign src_cx   = 33'(signed'(ONE_Q30));
            assign src_sy   = 33'sd0;
            assign src_frac = frac_in;
            assign src_quad = quad_in;
        end else begin : g_rest
            assign src_cx   = b_cx_reg[k-1];
            assign src_sy   = b_sy_reg[k-1];
            assign src_frac = b_frac_reg[k-1];
            assign src_quad = b_quad_reg[k-1];
        end
        assign nx = round_shift(a_pcc_reg[k] - a_pss_reg[k], 30);
        assign ny = round_shift(a_pcs_reg[k] + a_psc_reg[k], 30);
        always_ff @(posedge aclk) begin
            if (adv) begin
                a_pcc_reg[k]  <= src_cx * $signed(ROT.c);
                a_pss_reg[k]  <= src_sy * $signed(ROT.s);
                a_pcs_reg[k]  <= src_cx * $signed(ROT.s);
                a_psc_reg[k]  <= src_sy * $signed(ROT.c);
                a_cx_reg[k]   <= src_cx;
                a_sy_reg[k]   <= src_sy;
                a_frac_reg[k] <= src_frac;
                a_quad_reg[k] <= src_quad;
                b_frac_reg[k] <= a_frac_reg[k];
                b_quad_reg[k] <= a_quad_reg[k];
                if (a_frac_reg[k][ANGLE_STEPS - k]) begin
                    b_cx_reg[k] <= nx[32:0];
                    b_sy_reg[k] <= ny[32:0];
                end else begin
                    b_cx_reg[k] <= a_cx_reg[k];
                    b_sy_reg[k] <= a_sy_reg[k];
                end
            end
        end
    end

    // Map the quadrant by quarter turns.
    always_ff @(posedge aclk) begin
        if (adv) begin
            unique case (b_quad_reg[ANGLE_STEPS])
                QUAD_0: begin
                    cos_reg <= b_cx_reg[ANGLE_STEPS];
                    sin_reg <= b_sy_reg[ANGLE_STEPS];
                end
                QUAD_1: begin
                    cos_reg <= -b_sy_reg[ANGLE_STEPS];
                    sin_reg <= b_cx_reg[ANGLE_STEPS];
                end
                QUAD_2: begin
                    cos_reg <= -b_cx_reg[ANGLE_STEPS];
                    sin_reg <= -b_sy_reg[ANGLE_STEPS];
                end
                QUAD_3: begin
                    cos_reg <= b_sy_reg[ANGLE_STEPS];
                    sin_reg <= -b_cx_reg[ANGLE_STEPS];
                end
                default: begin
                    cos_reg <= b_cx_reg[ANGLE_STEPS];
                    sin_reg <= b_sy_reg[ANGLE_STEPS];
                end
            endcase
        end
    end

    assign cos_out = cos_reg;
    assign sin_out = sin_reg;

endmodule

[src/box_muller_gaussian.sv]
// Box-Muller normal sample generator.
// Input channel (s_): one transfer carries two uniform draws, the radius draw
// and the angle draw. Output channel (m_): one transfer carries the cosine
// and sine branch samples, each times spread_scale plus mean_offset, signed
// Q16.8 and saturated. Every input transfer gives exactly one output transfer.
// Configuration: APB port, mean_offset at address 0, spread_scale at 4; write
// only while the pipeline is empty.
// Depth: 66 register stages. Throughput: one item per cycle while the output
// is not stalled. The depth is capture, 30 two-stage angle rotations, the
// quadrant mapping register and four output stages; the radius path of 28 log
// squarings and 27 square-root bit steps runs in parallel, padded to match.
// Reset: clears all stage valid bits and loads mean 0 and spread 1.0.
// Stall: when the output holds a result that is not taken, the whole
// pipeline holds and s_ready drops; nothing is lost or repeated.
module box_muller_gaussian #(
    parameter int UNIFORM_BITS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [31:0]        s_uniform_radius,
    input  logic [31:0]        s_uniform_angle,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [23:0] m_first_sample,
    output logic signed [23:0] m_second_sample
);
    import bmg_pkg::*;

    localparam int EFF_BITS   = (UNIFORM_BITS > 32) ? 32 : UNIFORM_BITS;
    localparam int DROP       = 32 - EFF_BITS;
    localparam int PAD        = ANG_LAT - RAD_LAT;
    localparam int PIPE_DEPTH = 1 + ANG_LAT + FIN_STAGES;

    localparam logic REG_MEAN   = 1'b0;
    localparam logic REG_SPREAD = 1'b1;

    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [23:0]           mean_reg;
    logic [15:0]           spread_reg;

    logic [31:0]           m0_reg;
    logic [31:0]           ph0_reg;
    logic [26:0]           r_pad_reg [1:PAD];

    logic signed [63:0]    prod_c_reg;
    logic signed [63:0]    prod_s_reg;
    logic signed [31:0]    z_c_reg;
    logic signed [31:0]    z_s_reg;
    logic signed [48:0]    y_c_reg;
    logic signed [48:0]    y_s_reg;
    logic signed [23:0]    first_reg;
    logic signed [23:0]    second_reg;

    logic                  adv;
    logic [31:0]           m_shift;
    logic [31:0]           ph_next;
    logic [26:0]           r_val;
    logic signed [32:0]    cos_val;
    logic signed [32:0]    sin_val;
    logic signed [63:0]    z_c_full;
    logic signed [63:0]    z_s_full;
    logic signed [63:0]    w_c;
    logic signed [63:0]    w_s;
    logic signed [63:0]    mean_ext;

    // Advance every stage together whenever the output slot is free.
    assign adv     = !valid_reg[PIPE_DEPTH-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = valid_reg[PIPE_DEPTH-1];
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], s_valid};
        end
    end

    // Configuration writes; low address bits are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mean_reg   <= MEAN_RESET;
            spread_reg <= SPREAD_RESET;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                REG_MEAN:   mean_reg   <= pwdata[23:0];
                REG_SPREAD: spread_reg <= pwdata[15:0];
                default:    mean_reg   <= mean_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_MEAN:   prdata = {{8{mean_reg[23]}}, mean_reg};
            REG_SPREAD: prdata = {16'd0, spread_reg};
            default:    prdata = 32'd0;
        endcase
    end

    // Capture: keep only the used draw bits, and take a zero radius as one.
    assign m_shift = s_uniform_radius >> DROP;
    assign ph_next = (s_uniform_angle >> DROP) << DROP;

    always_ff @(posedge aclk) begin
        if (adv) begin
            m0_reg  <= (m_shift == 32'd0) ? 32'd1 : m_shift;
            ph0_reg <= ph_next;
        end
    end

    bmg_radius #(
        .EFF_BITS(EFF_BITS)
    ) u_radius (
        .aclk  (aclk),
        .adv   (adv),
        .m_in  (m0_reg),
        .r_out (r_val)
    );

    bmg_rotator u_rotator (
        .aclk    (aclk),
        .adv     (adv),
        .quad_in (ph0_reg[31:30]),
        .frac_in (ph0_reg[29:0]),
        .cos_out (cos_val),
        .sin_out (sin_val)
    );

    // Delay the radius to line up with the angle path.
    for (genvar i = 1; i <= PAD; i++) begin : g_pad
        always_ff @(posedge aclk) begin
            if (adv) begin
                r_pad_reg[i] <= (i == 1) ? r_val : r_pad_reg[(i == 1) ? 1 : i - 1];
            end
        end
    end

    assign z_c_full = round_shift(prod_c_reg, 30);
    assign z_s_full = round_shift(prod_s_reg, 30);
    assign mean_ext = 64'(signed'(mean_reg));
    assign w_c      = round_shift(64'(y_c_reg), 24) + mean_ext;
    assign w_s      = round_shift(64'(y_s_reg), 24) + mean_ext;

    // Output stages: r times trig, round, times spread, round, add mean, clamp.
    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_c_reg <= $signed({1'b0, r_pad_reg[PAD]}) * cos_val;
            prod_s_reg <= $signed({1'b0, r_pad_reg[PAD]}) * sin_val;
            z_c_reg    <= z_c_full[31:0];
            z_s_reg    <= z_s_full[31:0];
            y_c_reg    <= z_c_reg * $signed({1'b0, spread_reg});
            y_s_reg    <= z_s_reg * $signed({1'b0, spread_reg});
            priority if (w_c > SAMPLE_MAX) begin
                first_reg <= SAMPLE_MAX[23:0];
            end else if (w_c < SAMPLE_MIN) begin
                first_reg <= SAMPLE_MIN[23:0];
            end else begin
                first_reg <= w_c[23:0];
            end
            priority if (w_s > SAMPLE_MAX) begin
                second_reg <= SAMPLE_MAX[23:0];
            end else if (w_s < SAMPLE_MIN) begin
                second_reg <= SAMPLE_MIN[23:0];
            end else begin
                second_reg <= w_s[23:0];
            end
        end
    end

    assign m_first_sample  = first_reg;
    assign m_second_sample = second_reg;

endmodule

[src/bmg_checker.sv]
module bmg_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               pready,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [23:0] m_first_sample,
    input logic signed [23:0] m_second_sample
);

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_first_sample)
                                && $stable(m_second_sample))
        else $error("stalled result changed");

    // An empty output slot never blocks the input.
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty output");

    // A result leaving frees room for a new transfer in the same cycle.
    a_ready_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |-> s_ready)
        else $error("input blocked while output drains");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && pready)
        else $error("result offered after reset");

endmodule

bind box_muller_gaussian bmg_checker u_bmg_checker (.*);
